/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the duration parser.
// Depends on nothing; expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define WAV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check on every clock edge, reset included.
`define WAV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`endif

/* hdl/wavhdp_pkg.sv */
// Shared types and constants of the WAV header duration parser.
// Used by the front parser, the job queue and the divide back end.
`timescale 1ns / 1ps

package wavhdp_pkg;

	localparam int unsigned RIFF_HDR_LEN = 12;
	localparam int unsigned FMT_BODY_LEN = 16;
	localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
	localparam logic [30:0] DUR_MAX      = 31'h7FFF_FFFF;

	// Dividend 2*len + align*rate fits 49 bits; one quotient bit per step.
	localparam int unsigned DIV_W        = 49;
	localparam int unsigned DEN_W        = 48;

	// Parse phases of the front end.
	localparam logic [2:0] PH_SKIP_RIFF = 3'd0;
	localparam logic [2:0] PH_HDR_FMT   = 3'd1;
	localparam logic [2:0] PH_SKIP_FMT  = 3'd2;
	localparam logic [2:0] PH_FMT_BODY  = 3'd3;
	localparam logic [2:0] PH_FMT_EXTRA = 3'd4;
	localparam logic [2:0] PH_HDR_DATA  = 3'd5;
	localparam logic [2:0] PH_SKIP_DATA = 3'd6;
	localparam logic [2:0] PH_DONE      = 3'd7;

	typedef struct packed {
		logic        ok;
		logic [31:0] rate;
		logic [15:0] align;
		logic [31:0] length;
	} job_t;

endpackage

/* hdl/wav_header_duration_parser_unit.sv */
// WAV header duration parser, top level: front parser, job queue, divide back end.
// Throughput: one byte beat per cycle; in_ready drops only while the job queue is full.
// Path from the last byte beat to an ok result: queue, multiply, prepare, 49 divide steps,
// output; a failed file goes from queue to output. Back end pops a new file only when idle.
// Reset: arst_n clears parse state, queue and output valid asynchronously.
`timescale 1ns / 1ps

module wav_header_duration_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] duration_sec,
	output logic        status
);

	logic             q_full;
	logic             push;
	logic             pop;
	logic             not_empty;
	wavhdp_pkg::job_t push_job;
	wavhdp_pkg::job_t pop_job;

	wavhdp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	wavhdp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_job   (pop_job)
	);

	wavhdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.pop_job      (pop_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.duration_sec (duration_sec),
		.status       (status)
	);

endmodule

/* hdl/wavhdp_front.sv */
// Byte-level chunk walker: skips RIFF header, finds fmt and data chunks.
// Emits one job per file on the last byte. Depends on wavhdp_pkg.
`timescale 1ns / 1ps

module wavhdp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               q_full,
	output logic               push,
	output wavhdp_pkg::job_t   push_job
);

	logic [2:0]  phase_q, phase_n;
	logic [31:0] left_q, left_n;
	logic [3:0]  idx_q, idx_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] len_q, len_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] align_q, align_n;
	logic [31:0] pay_q, pay_n;
	logic [2:0]  hdr_i;
	logic        hdr_done;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign hdr_i    = idx_q[2:0];

	always_comb begin
		phase_n  = phase_q;
		left_n   = left_q;
		idx_n    = idx_q;
		tag_n    = tag_q;
		len_n    = len_q;
		rate_n   = rate_q;
		align_n  = align_q;
		pay_n    = pay_q;
		hdr_done = 1'b0;

		// Collect chunk header bytes: tag big-endian, length little-endian.
		if (phase_q == wavhdp_pkg::PH_HDR_FMT || phase_q == wavhdp_pkg::PH_HDR_DATA) begin
			unique case (hdr_i) inside
				3'd0, 3'd1, 3'd2, 3'd3: tag_n = {tag_q[23:0], data_byte};
				3'd4: len_n = {24'd0, data_byte};
				3'd5: len_n[15:8]  = len_q[15:8] | data_byte;
				3'd6: len_n[23:16] = len_q[23:16] | data_byte;
				3'd7: len_n[31:24] = len_q[31:24] | data_byte;
				default: ;
			endcase
			if (hdr_i == 3'd7) begin
				idx_n    = 4'd0;
				hdr_done = 1'b1;
			end else begin
				idx_n = {1'b0, hdr_i + 3'd1};
			end
		end

		unique case (phase_q) inside
			wavhdp_pkg::PH_SKIP_RIFF,
			wavhdp_pkg::PH_SKIP_FMT,
			wavhdp_pkg::PH_FMT_EXTRA,
			wavhdp_pkg::PH_SKIP_DATA: begin
				if (left_q <= 32'd1) begin
					left_n = 32'd0;
					if (phase_q == wavhdp_pkg::PH_SKIP_RIFF
						|| phase_q == wavhdp_pkg::PH_SKIP_FMT) begin
						phase_n = wavhdp_pkg::PH_HDR_FMT;
					end else begin
						phase_n = wavhdp_pkg::PH_HDR_DATA;
					end
				end else begin
					left_n = left_q - 32'd1;
				end
			end
			wavhdp_pkg::PH_HDR_FMT: begin
				if (hdr_done) begin
					if (tag_n == wavhdp_pkg::TAG_FMT) begin
						phase_n = wavhdp_pkg::PH_FMT_BODY;
					end else if (len_n == 32'd0) begin
						phase_n = wavhdp_pkg::PH_HDR_FMT;
					end else begin
						left_n  = len_n;
						phase_n = wavhdp_pkg::PH_SKIP_FMT;
					end
				end
			end
			wavhdp_pkg::PH_FMT_BODY: begin
				unique case (idx_q)
					4'd4:  rate_n = {24'd0, data_byte};
					4'd5:  rate_n[15:8]  = rate_q[15:8] | data_byte;
					4'd6:  rate_n[23:16] = rate_q[23:16] | data_byte;
					4'd7:  rate_n[31:24] = rate_q[31:24] | data_byte;
					4'd12: align_n = {8'd0, data_byte};
					4'd13: align_n[15:8] = align_q[15:8] | data_byte;
					default: ;
				endcase
				if (idx_q == 4'd15) begin
					idx_n = 4'd0;
					if (len_q > 32'(wavhdp_pkg::FMT_BODY_LEN)) begin
						left_n  = len_q - 32'(wavhdp_pkg::FMT_BODY_LEN);
						phase_n = wavhdp_pkg::PH_FMT_EXTRA;
					end else begin
						phase_n = wavhdp_pkg::PH_HDR_DATA;
					end
				end else begin
					idx_n = idx_q + 4'd1;
				end
			end
			wavhdp_pkg::PH_HDR_DATA: begin
				if (hdr_done) begin
					if (tag_n == wavhdp_pkg::TAG_DATA) begin
						pay_n   = len_n;
						phase_n = wavhdp_pkg::PH_DONE;
					end else if (len_n == 32'd0) begin
						phase_n = wavhdp_pkg::PH_HDR_DATA;
					end else begin
						left_n  = len_n;
						phase_n = wavhdp_pkg::PH_SKIP_DATA;
					end
				end
			end
			wavhdp_pkg::PH_DONE: ;
			default: ;
		endcase
	end

	assign push            = accept && last_byte;
	assign push_job.ok     = (phase_n == wavhdp_pkg::PH_DONE) && (rate_n != 32'd0)
		&& (align_n != 16'd0) && (pay_n != 32'd0);
	assign push_job.rate   = rate_n;
	assign push_job.align  = align_n;
	assign push_job.length = pay_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wavhdp_pkg::PH_SKIP_RIFF;
			left_q  <= 32'(wavhdp_pkg::RIFF_HDR_LEN);
			idx_q   <= 4'd0;
			tag_q   <= 32'd0;
			len_q   <= 32'd0;
			rate_q  <= 32'd0;
			align_q <= 16'd0;
			pay_q   <= 32'd0;
		end else if (accept) begin
			if (last_byte) begin
				// Start a new file after the last beat.
				phase_q <= wavhdp_pkg::PH_SKIP_RIFF;
				left_q  <= 32'(wavhdp_pkg::RIFF_HDR_LEN);
				idx_q   <= 4'd0;
				tag_q   <= 32'd0;
				len_q   <= 32'd0;
				rate_q  <= 32'd0;
				align_q <= 16'd0;
				pay_q   <= 32'd0;
			end else begin
				phase_q <= phase_n;
				left_q  <= left_n;
				idx_q   <= idx_n;
				tag_q   <= tag_n;
				len_q   <= len_n;
				rate_q  <= rate_n;
				align_q <= align_n;
				pay_q   <= pay_n;
			end
		end
	end

endmodule

/* hdl/wavhdp_queue.sv */
// Two-entry job queue between the parser front end and the divide back end.
// Depends on wavhdp_pkg for the job type.
`timescale 1ns / 1ps

module wavhdp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wavhdp_pkg::job_t   push_job,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output wavhdp_pkg::job_t   pop_job
);

	wavhdp_pkg::job_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* hdl/wavhdp_back.sv */
// Duration back end: multiply align by rate, then restoring divide of
// 2*len + den by 2*den, one quotient bit per cycle. Depends on wavhdp_pkg.
`timescale 1ns / 1ps

module wavhdp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  wavhdp_pkg::job_t   pop_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [30:0]        duration_sec,
	output logic               status
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam int unsigned CNT_W  = $clog2(wavhdp_pkg::DIV_W);

	logic [2:0]                     state_q;
	logic [31:0]                    rate_q;
	logic [15:0]                    align_q;
	logic [31:0]                    len_q;
	logic [wavhdp_pkg::DEN_W-1:0]   den_q;
	logic [wavhdp_pkg::DIV_W-1:0]   num_q;
	logic [wavhdp_pkg::DIV_W-1:0]   rem_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [30:0]                    dur_q;
	logic                           status_q;
	logic [wavhdp_pkg::DIV_W:0]     trial;
	logic [wavhdp_pkg::DIV_W:0]     divisor;
	logic [wavhdp_pkg::DIV_W:0]     diff;
	logic                           ge;
	logic [wavhdp_pkg::DIV_W-1:0]   quot_n;

	assign pop          = (state_q == ST_IDLE) && not_empty;
	assign out_valid    = (state_q == ST_OUT);
	assign duration_sec = dur_q;
	assign status       = status_q;

	assign trial   = {rem_q, num_q[wavhdp_pkg::DIV_W-1]};
	assign divisor = {1'b0, den_q, 1'b0};
	assign ge      = (trial >= divisor);
	assign diff    = trial - divisor;
	assign quot_n  = {num_q[wavhdp_pkg::DIV_W-2:0], ge};

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rate_q  <= pop_job.rate;
				align_q <= pop_job.align;
				len_q   <= pop_job.length;
			end
			ST_MUL: den_q <= {32'd0, align_q} * {16'd0, rate_q};
			ST_PREP: begin
				num_q <= {16'd0, len_q, 1'b0} + {1'b0, den_q};
				rem_q <= '0;
			end
			ST_DIV: begin
				// Shift the dividend out and the quotient bit in.
				num_q <= quot_n;
				rem_q <= ge ? diff[wavhdp_pkg::DIV_W-1:0] : trial[wavhdp_pkg::DIV_W-1:0];
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			dur_q    <= 31'd0;
			status_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (not_empty) begin
						if (pop_job.ok) begin
							state_q <= ST_MUL;
						end else begin
							dur_q    <= 31'd0;
							status_q <= 1'b1;
							state_q  <= ST_OUT;
						end
					end
				end
				ST_MUL: state_q <= ST_PREP;
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(wavhdp_pkg::DIV_W - 1)) begin
						// Saturate the quotient.
						if (quot_n[wavhdp_pkg::DIV_W-1:31] != '0) begin
							dur_q <= wavhdp_pkg::DUR_MAX;
						end else begin
							dur_q <= quot_n[30:0];
						end
						status_q <= 1'b0;
						state_q  <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/wavhdp_checker.sv */
// Port-level checks of the duration parser top level, bound to it below.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wavhdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] duration_sec,
	input logic        status
);

	`WAV_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte), "input beat changed while stalled")
	`WAV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(duration_sec) && $stable(status), "result beat changed while stalled")
	`WAV_ASSERT(a_fail_zero, out_valid && status |-> duration_sec == 31'd0, "failed result with nonzero duration")
	`WAV_ASSERT(a_one_beat, out_valid && out_ready |=> !out_valid, "result beat repeated")
	`WAV_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind wav_header_duration_parser_unit wavhdp_checker u_wavhdp_checker (.*);
